/* design/rfr_pkg.sv */
// Package for the request fragment reassembler.
// Holds the command and status codes, header constants and the result record.
// No dependencies.
`timescale 1ns / 1ps

package rfr_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_DISC    = 3'd2,
    CMD_FETCH   = 3'd3,
    CMD_RELEASE = 3'd4
  } rfr_cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_SUPP  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_NOT_ALLOW = 3'd3,
    ST_Q_FULL    = 3'd4
  } rfr_status_e;

  localparam logic [1:0] CFG_VERSION = 2'd0;
  localparam logic [1:0] CFG_TYPE    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned HDR_W     = 4;
  localparam logic [7:0] MAGIC0     = 8'h4C;
  localparam logic [7:0] MAGIC1     = 8'h4B;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [7:0]  TYPE_RST    = 8'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PW    = 2;

  typedef struct packed {
    logic        kind;
    rfr_status_e status;
    logic        head_valid;
    logic [31:0] head_id;
    logic [9:0]  head_len;
    logic [3:0]  head_conn;
    logic [7:0]  byte_val;
    logic [1:0]  count;
  } rfr_result_t;

endpackage

/* design/request_fragment_reassembler_top.sv */
// Top level of the request fragment reassembler.
// Header parse, reassembly state, payload memory and request queue.
// Depends on rfr_pkg and rfr_result_fifo.
`timescale 1ns / 1ps

// Takes one transaction per cycle (write byte, tick, disconnect, fetch, release);
// each reads, updates and writes back the reassembly state in that cycle and
// touches the single-port payload memory at most once. A write status or a
// fetched byte passes the pipeline register (the registered memory read for a
// byte) and then the result queue to the output. The three-entry queue keeps
// input accepted while results wait; the input stalls only when that queue,
// counting the result in the pipeline register, is full. The payload memory holds
// QUEUE_DEPTH+1 slots of MAX_PAYLOAD bytes and needs no clearing after reset.
module request_fragment_reassembler_top
  import rfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [3:0]  conn_id_i,
  input  logic        offset_nonzero_i,
  input  logic        prepare_write_i,
  input  logic [8:0]  fetch_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [2:0]  write_status_o,
  output logic        head_valid_o,
  output logic [31:0] head_request_id_o,
  output logic [9:0]  head_length_o,
  output logic [3:0]  head_conn_o,
  output logic [7:0]  fetched_byte_o,
  output logic [1:0]  queued_count_o
);

  localparam int unsigned SLOTS   = QUEUE_DEPTH + 1;
  localparam int unsigned SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW      = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned LIMIT   = HDR_BYTES + MAX_PAYLOAD + 1;
  localparam int unsigned CW      = $clog2(LIMIT + 1);
  localparam int unsigned PW      = CW + 1;
  localparam int unsigned AW      = $clog2(SLOTS * MAX_PAYLOAD);
  localparam int unsigned OW      = $clog2(MAX_PAYLOAD);

  logic [7:0]  version_q, type_q;
  logic [15:0] timeout_q;

  logic [7:0]  mem [SLOTS * MAX_PAYLOAD];
  logic [7:0]  rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic        mem_re;

  logic [7:0]  hdr_q [HDR_BYTES];
  logic        hdr_we;
  logic [HDR_W-1:0] hdr_idx;

  logic [LW-1:0] exp_q, exp_d, rcv_q, rcv_d;
  logic [CW-1:0] wcnt_q, wcnt_d;
  logic [31:0]   pid_q, pid_d;
  logic [3:0]    pconn_q, pconn_d;
  logic [15:0]   ticks_q, ticks_d;
  logic          wfirst_q, wfirst_d, wrej_q, wrej_d;
  logic [3:0]    wconn_q, wconn_d;

  logic [31:0]   sid_q [SLOTS];
  logic [LW-1:0] slen_q [SLOTS];
  logic [3:0]    sconn_q [SLOTS];
  logic          enq;
  logic [31:0]   enq_id;
  logic [LW-1:0] enq_len;
  logic [3:0]    enq_conn;

  logic [SW-1:0] head_q, head_d;
  logic [QW-1:0] qcnt_q, qcnt_d;
  logic [SW-1:0] tail;
  logic [SW:0]   tail_sum;

  logic        p_valid_q, p_valid_d, p_kind_q, p_kind_d, p_fok_q, p_fok_d;
  rfr_status_e p_st_q, p_st_d;

  logic        in_fire;
  rfr_result_t res;
  logic [1:0]  fifo_level;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign tail_sum = (SW + 1)'(head_q) + (SW + 1)'(qcnt_q);
  assign tail     = (tail_sum >= (SW + 1)'(SLOTS)) ? SW'(tail_sum - (SW + 1)'(SLOTS))
                                                   : SW'(tail_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VERSION_RST;
      type_q    <= TYPE_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERSION: version_q <= cfg_wdata_i[7:0];
        CFG_TYPE:    type_q    <= cfg_wdata_i[7:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic          rej, last;
    logic          first;
    logic [CW-1:0] idx, len, frag;
    logic [PW-1:0] pos;
    logic [15:0]   plen;
    logic [3:0]    cw;
    rfr_status_e   st;
    logic          done;

    rej   = 1'b0;
    last  = 1'b0;
    first = 1'b0;
    idx   = wcnt_q;
    len   = '0;
    frag  = '0;
    pos   = '0;
    plen  = '0;
    cw    = '0;
    st    = ST_OK;
    done  = 1'b0;

    exp_d     = exp_q;
    rcv_d     = rcv_q;
    wcnt_d    = wcnt_q;
    pid_d     = pid_q;
    pconn_d   = pconn_q;
    ticks_d   = ticks_q;
    wfirst_d  = wfirst_q;
    wrej_d    = wrej_q;
    wconn_d   = wconn_q;
    head_d    = head_q;
    qcnt_d    = qcnt_q;
    enq       = 1'b0;
    enq_id    = '0;
    enq_len   = '0;
    enq_conn  = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    hdr_we    = 1'b0;
    hdr_idx   = '0;
    p_valid_d = 1'b0;
    p_kind_d  = 1'b0;
    p_fok_d   = 1'b0;
    p_st_d    = ST_OK;

    if (in_fire) begin
      unique case (rfr_cmd_e'(command_i))
        CMD_WRITE: begin
          if (idx == '0) begin
            rej = offset_nonzero_i | prepare_write_i;
            cw  = conn_id_i;
            if (!rej && exp_d != '0 && ticks_q > timeout_q) begin
              exp_d = '0; rcv_d = '0; pid_d = '0; pconn_d = '0; ticks_d = '0;
            end
            first = (exp_d == '0);
          end else begin
            rej   = wrej_q;
            cw    = wconn_q;
            first = wfirst_q;
          end
          wrej_d   = rej;
          wconn_d  = cw;
          wfirst_d = first;
          if (!rej) begin
            if (first) begin
              if (idx < CW'(HDR_BYTES)) begin
                hdr_we  = 1'b1;
                hdr_idx = HDR_W'(idx);
              end else if (idx - CW'(HDR_BYTES) < CW'(MAX_PAYLOAD)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(tail) * AW'(MAX_PAYLOAD) + AW'(idx - CW'(HDR_BYTES));
              end
            end else begin
              pos = PW'(rcv_d) + PW'(idx);
              if (pos < PW'(exp_d)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(tail) * AW'(MAX_PAYLOAD) + AW'(pos);
              end
            end
          end
          len    = (wcnt_q < CW'(LIMIT)) ? wcnt_q + 1'b1 : wcnt_q;
          wcnt_d = len;
          last   = last_byte_i;
          if (last) begin
            wcnt_d    = '0;
            p_valid_d = 1'b1;
            if (rej) begin
              st = ST_NOT_SUPP;
            end else if (first) begin
              plen = {hdr_q[9], hdr_q[8]};
              frag = len - CW'(HDR_BYTES);
              if (len < CW'(HDR_BYTES)) begin
                st = ST_BAD_LEN;
              end else if (hdr_q[0] != MAGIC0 || hdr_q[1] != MAGIC1 ||
                           hdr_q[2] != version_q || hdr_q[3] != type_q) begin
                st = ST_NOT_ALLOW;
              end else if (plen == 16'd0 || plen > 16'(MAX_PAYLOAD) ||
                           frag > CW'(plen)) begin
                st = ST_BAD_LEN;
              end else begin
                pid_d   = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
                pconn_d = cw;
                exp_d   = LW'(plen);
                rcv_d   = LW'(frag);
                ticks_d = '0;
                done    = 1'b1;
              end
            end else begin
              if (exp_d == '0) begin
                st = ST_NOT_ALLOW;
              end else if (len > CW'(exp_d - rcv_d) || cw != pconn_d) begin
                exp_d = '0; rcv_d = '0; pid_d = '0; pconn_d = '0; ticks_d = '0;
                st    = ST_NOT_ALLOW;
              end else begin
                rcv_d = rcv_d + LW'(len);
                done  = 1'b1;
              end
            end
            if (done && rcv_d == exp_d) begin
              if (qcnt_q < QW'(QUEUE_DEPTH)) begin
                enq      = 1'b1;
                enq_id   = pid_d;
                enq_len  = exp_d;
                enq_conn = pconn_d;
                qcnt_d   = qcnt_q + 1'b1;
              end else begin
                st = ST_Q_FULL;
              end
              exp_d = '0; rcv_d = '0; pid_d = '0; pconn_d = '0; ticks_d = '0;
            end
            p_st_d = st;
          end
        end
        CMD_TICK: begin
          if (exp_q != '0 && ticks_q < TICK_MAX) begin
            ticks_d = ticks_q + 1'b1;
          end
        end
        CMD_DISC: begin
          if (exp_q != '0 && pconn_q == conn_id_i) begin
            exp_d = '0; rcv_d = '0; pid_d = '0; pconn_d = '0; ticks_d = '0;
          end
          head_d = tail;
          qcnt_d = '0;
        end
        CMD_FETCH: begin
          p_valid_d = 1'b1;
          p_kind_d  = 1'b1;
          if (qcnt_q != '0 && LW'(fetch_index_i) < slen_q[head_q]) begin
            p_fok_d   = 1'b1;
            mem_re    = 1'b1;
            mem_raddr = AW'(head_q) * AW'(MAX_PAYLOAD) + AW'(OW'(fetch_index_i));
          end
        end
        CMD_RELEASE: begin
          if (qcnt_q != '0) begin
            head_d = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
            qcnt_d = qcnt_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= data_byte_i;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
    if (hdr_we) begin
      hdr_q[hdr_idx] <= data_byte_i;
    end
    if (enq) begin
      sid_q[tail]   <= enq_id;
      slen_q[tail]  <= enq_len;
      sconn_q[tail] <= enq_conn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q     <= '0;
      rcv_q     <= '0;
      wcnt_q    <= '0;
      pid_q     <= '0;
      pconn_q   <= '0;
      ticks_q   <= '0;
      wfirst_q  <= 1'b0;
      wrej_q    <= 1'b0;
      wconn_q   <= '0;
      head_q    <= '0;
      qcnt_q    <= '0;
      p_valid_q <= 1'b0;
      p_kind_q  <= 1'b0;
      p_fok_q   <= 1'b0;
      p_st_q    <= ST_OK;
    end else begin
      exp_q     <= exp_d;
      rcv_q     <= rcv_d;
      wcnt_q    <= wcnt_d;
      pid_q     <= pid_d;
      pconn_q   <= pconn_d;
      ticks_q   <= ticks_d;
      wfirst_q  <= wfirst_d;
      wrej_q    <= wrej_d;
      wconn_q   <= wconn_d;
      head_q    <= head_d;
      qcnt_q    <= qcnt_d;
      p_valid_q <= p_valid_d;
      p_kind_q  <= p_kind_d;
      p_fok_q   <= p_fok_d;
      p_st_q    <= p_st_d;
    end
  end

  always_comb begin
    res            = '0;
    res.kind       = p_kind_q;
    res.status     = p_st_q;
    res.count      = 2'(qcnt_q);
    res.byte_val   = p_fok_q ? rdata_q : 8'd0;
    res.head_valid = (qcnt_q != '0);
    if (qcnt_q != '0) begin
      res.head_id   = sid_q[head_q];
      res.head_len  = 10'(slen_q[head_q]);
      res.head_conn = sconn_q[head_q];
    end
  end

  rfr_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p_valid_q),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  ({result_kind_o, write_status_o, head_valid_o, head_request_id_o,
                   head_length_o, head_conn_o, fetched_byte_o, queued_count_o}),
    .level_o     (fifo_level)
  );

  assign in_stall_o = (3'(fifo_level) + 3'(p_valid_q)) >= 3'(OUT_DEPTH);

endmodule

/* design/rfr_result_fifo.sv */
// Result queue of the request fragment reassembler.
// Three-entry register FIFO that decouples the pipeline from the output stall.
// Depends on rfr_pkg.
`timescale 1ns / 1ps

module rfr_result_fifo
  import rfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rfr_result_t push_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output rfr_result_t out_data_o,
  output logic [1:0]  level_o
);

  rfr_result_t              mem_q [OUT_DEPTH];
  logic [OUT_PW-1:0]        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]               cnt_q, cnt_d;
  logic                     pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign level_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == OUT_PW'(OUT_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule
